### rtl/core/dpqa_pkg.sv
// Shared types and constants for the deadline priority queue assignment block.
package dpqa_pkg;

    localparam int KIND_W      = 2;
    localparam int TIME_W      = 63;
    localparam int PRIO_W      = 31;
    localparam int QUEUE_W     = 5;
    localparam int LVL_IDX_W   = 8;
    localparam int MAX_LEVELS_DEF = 32;

    // 1000000 = 2**6 * 15625; the shift drops the power of two, the
    // reciprocal multiply handles the odd factor
    localparam int MS_SHIFT    = 6;
    localparam int DIVD_W      = 45;
    localparam int HALF_W      = 23;
    localparam int PROD_W      = 2 * HALF_W;
    localparam int RECIP_SH    = 59;
    localparam int SUM_W       = 91;

    localparam logic [63:0]       MS_ODD    = 64'd15625;
    localparam logic [PROD_W-1:0] RECIP     =
        PROD_W'(((64'd1 << RECIP_SH) + MS_ODD - 64'd1) / MS_ODD);
    localparam logic [PRIO_W-1:0] PRIO_MAX  = {PRIO_W{1'b1}};
    // smallest time value whose millisecond count no longer fits
    localparam logic [TIME_W-1:0] SAT_NS    = 63'd2147483648000000;

    typedef enum logic [KIND_W-1:0] {
        KIND_NRT      = 2'd0,
        KIND_PERIODIC = 2'd1,
        KIND_SPORADIC = 2'd2,
        KIND_RT       = 2'd3
    } t_kind;

    typedef struct packed {
        logic                 active;
        logic                 found;
        logic [LVL_IDX_W-1:0] slot;
    } t_tok;

endpackage

### rtl/core/deadline_priority_queue_assign.sv
// Top level: deadline-monotonic priority assignment with a systolic level table search.
// Flow from input item to result: the reciprocal multiply, then the search token walks the chain,
// then the table is updated and the output register is loaded. One item is in work at a time,
// and a new item is taken while the previous result waits in the output register.
// Reset: synchronous active low; clears level count, control and output valid.
module deadline_priority_queue_assign #(
    parameter int MAX_LEVELS = dpqa_pkg::MAX_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dpqa_pkg::KIND_W-1:0]   i_task_kind,
    input  logic [dpqa_pkg::TIME_W-1:0]   i_time_ns,
    input  logic                          i_inherit_present,
    input  logic [dpqa_pkg::QUEUE_W-1:0]  i_inherit_queue,
    input  logic [dpqa_pkg::PRIO_W-1:0]   i_inherit_priority,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dpqa_pkg::PRIO_W-1:0]   o_base_priority,
    output logic [dpqa_pkg::QUEUE_W-1:0]  o_base_queue,
    output logic [dpqa_pkg::PRIO_W-1:0]   o_active_priority,
    output logic [dpqa_pkg::QUEUE_W-1:0]  o_active_queue,
    output logic                          o_status
);
    import dpqa_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEVELS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SRCH = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovalid;

    logic               r_inh;
    logic [QUEUE_W-1:0] r_inh_q;
    logic [PRIO_W-1:0]  r_inh_p;
    logic               r_found;
    logic               r_full;
    logic [LVL_IDX_W-1:0] r_slot;

    logic [PRIO_W-1:0]  r_o_base_p;
    logic [QUEUE_W-1:0] r_o_base_q;
    logic [PRIO_W-1:0]  r_o_act_p;
    logic [QUEUE_W-1:0] r_o_act_q;
    logic               r_o_status;

    logic               w_accept;
    logic               w_div_done;
    logic [PRIO_W-1:0]  w_key;
    t_tok               w_tok [MAX_LEVELS+1];
    t_tok               w_last;
    logic               w_room;
    logic               w_wr_en;
    logic               w_out_free;
    logic [QUEUE_W-1:0] w_base_q;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_last     = w_tok[MAX_LEVELS];
    assign w_room     = r_count < CNT_W'(MAX_LEVELS);
    assign w_wr_en    = (r_state == S_SRCH) && w_last.active && !w_last.found && w_room;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_base_q   = QUEUE_W'(r_slot);

    dpqa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_kind    (i_task_kind),
        .i_time_ns (i_time_ns),
        .o_done    (w_div_done),
        .o_quot    (w_key)
    );

    assign w_tok[0] = '{active: w_div_done, found: 1'b0, slot: '0};

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        dpqa_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .i_key     (w_key),
            .i_count   (r_count),
            .i_wr_en   (w_wr_en),
            .i_wr_idx  (LVL_IDX_W'(r_count)),
            .i_wr_data (w_key)
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_SRCH;
            end
            S_SRCH: begin
                if (w_last.active) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_inh   <= i_inherit_present;
            r_inh_q <= i_inherit_queue;
            r_inh_p <= i_inherit_priority;
        end
        if ((r_state == S_SRCH) && w_last.active) begin
            r_found <= w_last.found;
            r_full  <= !w_last.found && !w_room;
            if (w_last.found) begin
                r_slot <= w_last.slot;
            end else if (w_room) begin
                r_slot <= LVL_IDX_W'(r_count);
            end else begin
                r_slot <= '0;
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_base_p <= w_key;
            r_o_base_q <= w_base_q;
            r_o_act_p  <= r_inh ? r_inh_p : w_key;
            r_o_act_q  <= r_inh ? r_inh_q : w_base_q;
            r_o_status <= r_full && !r_found;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_base_priority   = r_o_base_p;
    assign o_base_queue      = r_o_base_q;
    assign o_active_priority = r_o_act_p;
    assign o_active_queue    = r_o_act_q;
    assign o_status          = r_o_status;

endmodule

### rtl/core/dpqa_div.sv
// Base priority unit: ns to ms by a three-stage multiply with a fixed-point reciprocal.
module dpqa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dpqa_pkg::KIND_W-1:0]   i_kind,
    input  logic [dpqa_pkg::TIME_W-1:0]   i_time_ns,
    output logic                          o_done,
    output logic [dpqa_pkg::PRIO_W-1:0]   o_quot
);
    import dpqa_pkg::*;

    logic                  r_done;
    logic [2:0]            r_stage;
    logic                  r_sat;
    logic [DIVD_W-1:0]     r_y;
    logic [PROD_W-1:0]     r_p_ll;
    logic [PROD_W-1:0]     r_p_lh;
    logic [PROD_W-1:0]     r_p_hl;
    logic [PROD_W-1:0]     r_p_hh;
    logic [PROD_W:0]       r_mid;
    logic [PRIO_W-1:0]     r_res;

    logic [HALF_W-1:0]     w_y_lo;
    logic [HALF_W-1:0]     w_y_hi;
    logic [HALF_W-1:0]     w_m_lo;
    logic [HALF_W-1:0]     w_m_hi;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_sat;

    assign w_y_lo = r_y[HALF_W-1:0];
    assign w_y_hi = HALF_W'(r_y[DIVD_W-1:HALF_W]);
    assign w_m_lo = RECIP[HALF_W-1:0];
    assign w_m_hi = RECIP[PROD_W-1:HALF_W];
    assign w_sum  = (SUM_W'(r_p_hh) << PROD_W) + (SUM_W'(r_mid) << HALF_W) + SUM_W'(r_p_ll);
    assign w_sat  = (t_kind'(i_kind) == KIND_NRT) || (i_time_ns >= SAT_NS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            r_done  <= r_stage[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // bits above the slice are zero whenever the quotient fits
            r_y   <= i_time_ns[MS_SHIFT+DIVD_W-1:MS_SHIFT];
            r_sat <= w_sat;
        end
        if (r_stage[0]) begin
            r_p_ll <= PROD_W'(w_y_lo) * PROD_W'(w_m_lo);
            r_p_lh <= PROD_W'(w_y_lo) * PROD_W'(w_m_hi);
            r_p_hl <= PROD_W'(w_y_hi) * PROD_W'(w_m_lo);
            r_p_hh <= PROD_W'(w_y_hi) * PROD_W'(w_m_hi);
        end
        if (r_stage[1]) begin
            r_mid <= (PROD_W+1)'(r_p_lh) + (PROD_W+1)'(r_p_hl);
        end
        if (r_stage[2]) begin
            r_res <= r_sat ? PRIO_MAX : w_sum[RECIP_SH+PRIO_W-1:RECIP_SH];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

### rtl/core/dpqa_cell.sv
// One level table slot: holds a level and compares it against the passing search token.
module dpqa_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dpqa_pkg::t_tok                  i_tok,
    output dpqa_pkg::t_tok                  o_tok,
    input  logic [dpqa_pkg::PRIO_W-1:0]     i_key,
    input  logic [CNT_W-1:0]                i_count,
    input  logic                            i_wr_en,
    input  logic [dpqa_pkg::LVL_IDX_W-1:0]  i_wr_idx,
    input  logic [dpqa_pkg::PRIO_W-1:0]     i_wr_data
);
    import dpqa_pkg::*;

    logic [PRIO_W-1:0] r_level;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              w_hit;

    assign w_hit = (CNT_W'(IDX) < i_count) && (r_level == i_key);

    always_comb begin
        n_tok.active = i_tok.active;
        n_tok.found  = i_tok.found | w_hit;
        n_tok.slot   = i_tok.found ? i_tok.slot : LVL_IDX_W'(IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == LVL_IDX_W'(IDX))) begin
            r_level <= i_wr_data;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/dpqa_chk.sv
// Port-level checker for the deadline priority queue assignment block, with its bind.
module dpqa_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [dpqa_pkg::KIND_W-1:0]   i_task_kind,
    input logic [dpqa_pkg::TIME_W-1:0]   i_time_ns,
    input logic                          i_inherit_present,
    input logic [dpqa_pkg::QUEUE_W-1:0]  i_inherit_queue,
    input logic [dpqa_pkg::PRIO_W-1:0]   i_inherit_priority,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [dpqa_pkg::PRIO_W-1:0]   o_base_priority,
    input logic [dpqa_pkg::QUEUE_W-1:0]  o_base_queue,
    input logic [dpqa_pkg::PRIO_W-1:0]   o_active_priority,
    input logic [dpqa_pkg::QUEUE_W-1:0]  o_active_queue,
    input logic                          o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_base_priority) && $stable(o_base_queue)
            && $stable(o_active_priority) && $stable(o_active_queue) && $stable(o_status))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while one is in work");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_base_queue == '0)
        else $error("table full result carries a nonzero base queue");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind deadline_priority_queue_assign dpqa_chk u_dpqa_chk (.*);
